/* rtl/akd_pkg.sv */
// ---------------------------------------------------------------------------
// akd_pkg: shared types, constants and functions
// Item formats, event codes, register indexes and the sample scaling used by
// the keypad decoder front and back.
// ---------------------------------------------------------------------------
package akd_pkg;

  localparam int NUM_KEYS = 6;

  localparam logic [2:0] NO_KEY    = 3'd6;
  localparam logic [6:0] COUNT_MAX = 7'd100;

  localparam logic [2:0] CFG_MATCH_MARGIN  = 3'd6;
  localparam logic [2:0] CFG_QUALIFY_COUNT = 3'd7;

  localparam logic [7:0] LEVEL_RESET [NUM_KEYS] = '{8'd12, 8'd57, 8'd85, 8'd101,
                                                    8'd114, 8'd123};
  localparam logic [7:0] MARGIN_RESET  = 8'd5;
  localparam logic [6:0] QUALIFY_RESET = 7'd3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef struct packed {
    logic       is_poll;
    logic       advance;
    logic       release_f;
    logic [7:0] scaled;
  } cmd_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] key_index;
    logic [7:0] scaled_level;
  } res_t;

  // sample * 200 / 63 = 3 * sample + (11 * sample) / 63. The second term is
  // small, and ((y + 1) * 65) >> 12 equals y / 63 for every y up to 693.
  function automatic logic [7:0] scale_sample(input logic [5:0] sample);
    logic [9:0]  y;
    logic [15:0] prod;
    logic [7:0]  triple;
    y      = 10'(sample) * 10'd11;
    prod   = (16'(y) + 16'd1) * 16'd65;
    triple = 8'(sample) * 8'd3;
    return triple + {4'd0, prod[15:12]};
  endfunction

endpackage

/* rtl/akd_front.sv */
// ---------------------------------------------------------------------------
// akd_front: item classification
// Turns an incoming item into a command for the back end: poll or interrupt,
// whether the press counter advances, whether a release occurs, and the
// sample already scaled to the 0..200 level range.
// ---------------------------------------------------------------------------
module akd_front (
  input  logic              action,
  input  logic              sample_flag,
  input  logic              press_flag,
  input  logic              release_flag,
  input  logic [5:0]        adc_sample,
  output akd_pkg::cmd_t     cmd
);

  always_comb begin
    cmd.is_poll   = action;
    cmd.advance   = !action && (sample_flag || press_flag);
    cmd.release_f = !action && release_flag;
    cmd.scaled    = akd_pkg::scale_sample(adc_sample);
  end

endmodule

/* rtl/akd_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// akd_cmd_fifo: command queue
// Two-entry queue that carries classified commands from the front to the
// back end so that either side can stall on its own.
// ---------------------------------------------------------------------------
module akd_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  akd_pkg::cmd_t     push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output akd_pkg::cmd_t     pop_data
);

  akd_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r;
  logic          wr_ptr_nxt;
  logic          rd_ptr_r;
  logic          rd_ptr_nxt;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/akd_back.sv */
// ---------------------------------------------------------------------------
// akd_back: command execution
// Holds the configuration and decoder state and, while the two-entry result
// queue has room, executes one command per cycle, queueing one result each.
// ---------------------------------------------------------------------------
module akd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  akd_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_event_kind,
  output logic [2:0]        out_key_index,
  output logic [7:0]        out_scaled_level
);

  logic [7:0]       key_level_r [akd_pkg::NUM_KEYS];
  logic [7:0]       margin_r;
  logic [6:0]       qualify_r;

  logic [6:0]       counter_r;
  logic [6:0]       counter_nxt;
  akd_pkg::event_t  event_r;
  akd_pkg::event_t  event_nxt;
  logic [7:0]       level_r;
  logic [7:0]       level_nxt;

  akd_pkg::res_t    res_mem_r [2];
  logic             res_wr_r;
  logic             res_rd_r;
  logic [1:0]       res_count_r;
  logic [1:0]       res_count_nxt;
  akd_pkg::res_t    res;
  logic             do_out_pop;

  logic [2:0]       match;
  logic [6:0]       counter_adv;

  assign out_empty        = (res_count_r == 2'd0);
  assign do_out_pop       = out_pop && !out_empty;
  assign cmd_pop          = cmd_valid && ((res_count_r != 2'd2) || do_out_pop);
  assign out_event_kind   = res_mem_r[res_rd_r].event_kind;
  assign out_key_index    = res_mem_r[res_rd_r].key_index;
  assign out_scaled_level = res_mem_r[res_rd_r].scaled_level;

  // The lowest key whose window strictly contains the latched level wins.
  always_comb begin
    logic [8:0] lo_sum;
    logic [8:0] hi_sum;
    match = akd_pkg::NO_KEY;
    for (int i = akd_pkg::NUM_KEYS - 1; i >= 0; i--) begin
      lo_sum = {1'b0, level_r} + {1'b0, margin_r};
      hi_sum = {1'b0, key_level_r[i]} + {1'b0, margin_r};
      if ((lo_sum > {1'b0, key_level_r[i]}) && ({1'b0, level_r} < hi_sum)) begin
        match = 3'(i);
      end
    end
  end

  always_comb begin
    counter_nxt = counter_r;
    event_nxt   = event_r;
    level_nxt   = level_r;
    res         = '{event_kind: akd_pkg::EV_NONE, key_index: akd_pkg::NO_KEY,
                    scaled_level: 8'd0};
    counter_adv = (cmd.advance && (counter_r < akd_pkg::COUNT_MAX)) ?
                  counter_r + 7'd1 : counter_r;
    if (cmd_pop) begin
      if (cmd.is_poll) begin
        res.event_kind   = event_r;
        res.key_index    = (event_r == akd_pkg::EV_PRESS) ? match : akd_pkg::NO_KEY;
        res.scaled_level = level_r;
        event_nxt        = akd_pkg::EV_NONE;
      end else begin
        counter_nxt = counter_adv;
        if (counter_adv == qualify_r) begin
          event_nxt = akd_pkg::EV_PRESS;
          level_nxt = cmd.scaled;
        end
        if (cmd.release_f) begin
          counter_nxt = 7'd0;
          event_nxt   = akd_pkg::EV_RELEASE;
        end
      end
    end
    res_count_nxt = res_count_r + 2'(cmd_pop) - 2'(do_out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
        key_level_r[i] <= akd_pkg::LEVEL_RESET[i];
      end
      margin_r    <= akd_pkg::MARGIN_RESET;
      qualify_r   <= akd_pkg::QUALIFY_RESET;
      counter_r   <= 7'd0;
      event_r     <= akd_pkg::EV_NONE;
      level_r     <= 8'd0;
      res_wr_r    <= 1'b0;
      res_rd_r    <= 1'b0;
      res_count_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
          if (cfg_index == 3'(i)) begin
            key_level_r[i] <= cfg_data;
          end
        end
        if (cfg_index == akd_pkg::CFG_MATCH_MARGIN) begin
          margin_r <= cfg_data;
        end
        if (cfg_index == akd_pkg::CFG_QUALIFY_COUNT) begin
          qualify_r <= cfg_data[6:0];
        end
      end
      counter_r   <= counter_nxt;
      event_r     <= event_nxt;
      level_r     <= level_nxt;
      res_wr_r    <= cmd_pop ? !res_wr_r : res_wr_r;
      res_rd_r    <= do_out_pop ? !res_rd_r : res_rd_r;
      res_count_r <= res_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

endmodule

/* rtl/adc_ladder_key_decoder.sv */
// ---------------------------------------------------------------------------
// adc_ladder_key_decoder: resistor-ladder keypad decoder
// Tracks interrupt flags from a 6-bit converter and reports key events.
//
// The input side is a queue: an item is taken at a clock edge with in_push
// high and in_full low. Interrupt items advance the press counter on a
// sample or press flag, latch the scaled sample whenever the counter equals
// the qualify count, and record releases. Poll items report and clear the
// recorded event and for a press name the first key whose window holds the
// latched level. Every item yields exactly one result; interrupt results
// are all zero except a key index of 6.
// The result side is a queue: a result is shown while out_empty is low and
// taken at an edge with out_pop high. An item waits in the command queue,
// and its result is registered into the result queue when the back end takes
// it. One item per cycle is sustained while results are popped, set by the
// single execute stage in the back end. If the receiver stalls, the two-entry
// result queue and then the two-entry command queue fill before in_full rises.
// The cfg port writes a register at any edge with cfg_we high; it is meant
// for use while the block is idle. Synchronous reset empties both queues,
// clears the decoder state and restores every register to its default.
// ---------------------------------------------------------------------------
module adc_ladder_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic        in_sample_flag,
  input  logic        in_press_flag,
  input  logic        in_release_flag,
  input  logic [5:0]  in_adc_sample,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_event_kind,
  output logic [2:0]  out_key_index,
  output logic [7:0]  out_scaled_level,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  akd_pkg::cmd_t front_cmd;
  akd_pkg::cmd_t queued_cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  akd_front u_front (
    .action       (in_action),
    .sample_flag  (in_sample_flag),
    .press_flag   (in_press_flag),
    .release_flag (in_release_flag),
    .adc_sample   (in_adc_sample),
    .cmd          (front_cmd)
  );

  akd_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .pop_data  (queued_cmd)
  );

  akd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (queued_cmd),
    .cmd_pop          (cmd_pop),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_kind   (out_event_kind),
    .out_key_index    (out_key_index),
    .out_scaled_level (out_scaled_level)
  );

endmodule

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for adc_ladder_key_decoder
// Drives interrupt and poll items through the input queue, predicts every
// result with a cycle-free model of the press counter, the event register,
// the latched level and the key windows, and compares each popped result
// field by field. Covers directed corner cases, counter saturation, a long
// receiver stall and random phases under several register settings.
// ---------------------------------------------------------------------------
module testbench;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 170;
  localparam int STALL_CYCLES  = 300;
  localparam int LEVEL_SPAN    = 200;
  localparam int SAMPLE_SPAN   = 63;

  localparam logic       ACT_INTERRUPT   = 1'b0;
  localparam logic       ACT_POLL        = 1'b1;
  localparam logic [2:0] CFG_KEY_LEVEL_0 = 3'd0;

  // Samples whose scaled value lands on each default key level.
  localparam logic [5:0] KEY_SAMPLE [akd_pkg::NUM_KEYS] =
    '{6'd4, 6'd18, 6'd27, 6'd32, 6'd36, 6'd39};

  typedef struct packed {
    logic       poll;
    logic       sample_flag;
    logic       press_flag;
    logic       release_flag;
    logic [5:0] adc_sample;
  } key_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_action;
  logic       in_sample_flag;
  logic       in_press_flag;
  logic       in_release_flag;
  logic [5:0] in_adc_sample;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_event_kind;
  logic [2:0] out_key_index;
  logic [7:0] out_scaled_level;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  logic [7:0]      key_level [akd_pkg::NUM_KEYS];
  logic [7:0]      window_margin;
  logic [6:0]      qualify_at;
  logic [6:0]      press_count;
  akd_pkg::event_t pending_event;
  logic [7:0]      held_level;

  akd_pkg::res_t expected_results [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  int   pop_wait = 0;
  bit   steady = 1'b0;

  adc_ladder_key_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_sample_flag   (in_sample_flag),
    .in_press_flag    (in_press_flag),
    .in_release_flag  (in_release_flag),
    .in_adc_sample    (in_adc_sample),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_kind   (out_event_kind),
    .out_key_index    (out_key_index),
    .out_scaled_level (out_scaled_level),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [2:0] match_key();
    int lvl;
    int m;
    int c;
    lvl = held_level;
    m   = window_margin;
    for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
      c = key_level[i];
      if (lvl > c - m && lvl < c + m) return 3'(i);
    end
    return akd_pkg::NO_KEY;
  endfunction

  function automatic akd_pkg::res_t predict_key_result(key_item_t it);
    akd_pkg::res_t r;
    r.event_kind   = akd_pkg::EV_NONE;
    r.key_index    = akd_pkg::NO_KEY;
    r.scaled_level = '0;
    if (it.poll == ACT_INTERRUPT) begin
      if ((it.sample_flag || it.press_flag) && press_count < akd_pkg::COUNT_MAX)
        press_count = press_count + 7'd1;
      if (press_count == qualify_at) begin
        pending_event = akd_pkg::EV_PRESS;
        held_level    = 8'((int'(it.adc_sample) * LEVEL_SPAN) / SAMPLE_SPAN);
      end
      if (it.release_flag) begin
        press_count   = '0;
        pending_event = akd_pkg::EV_RELEASE;
      end
    end else begin
      r.event_kind   = pending_event;
      r.key_index    = (pending_event == akd_pkg::EV_PRESS) ? match_key() : akd_pkg::NO_KEY;
      r.scaled_level = held_level;
      pending_event  = akd_pkg::EV_NONE;
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: ERROR %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    akd_pkg::res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: ERROR unexpected result, expected none, actual %0d/%0d/%0d",
                 $time, out_event_kind, out_key_index, out_scaled_level);
      end else begin
        want = expected_results.pop_front();
        check_field("event_kind", want.event_kind, out_event_kind);
        check_field("key_index", want.key_index, out_key_index);
        check_field("scaled_level", want.scaled_level, out_scaled_level);
      end
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (pop_wait > 0) begin
        out_pop <= 1'b0;
        pop_wait--;
      end else begin
        out_pop  <= 1'b1;
        pop_wait = steady ? 0 : pick_gap();
      end
    end
  end

  function automatic key_item_t make_item(logic poll, logic sf, logic pf, logic rf,
                                          logic [5:0] sample);
    key_item_t it;
    it.poll         = poll;
    it.sample_flag  = sf;
    it.press_flag   = pf;
    it.release_flag = rf;
    it.adc_sample   = sample;
    return it;
  endfunction

  task automatic send_item(key_item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_action       <= it.poll;
    in_sample_flag  <= it.sample_flag;
    in_press_flag   <= it.press_flag;
    in_release_flag <= it.release_flag;
    in_adc_sample   <= it.adc_sample;
    do @(posedge clk); while (in_full);
    expected_results.push_back(predict_key_result(it));
  endtask

  task automatic send_irq(logic sf, logic pf, logic rf, logic [5:0] sample);
    send_item(make_item(ACT_INTERRUPT, sf, pf, rf, sample));
  endtask

  task automatic send_poll();
    send_item(make_item(ACT_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == akd_pkg::CFG_MATCH_MARGIN) window_margin = data;
    else if (idx == akd_pkg::CFG_QUALIFY_COUNT) qualify_at = data[6:0];
    else key_level[idx - CFG_KEY_LEVEL_0] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(logic [8*akd_pkg::NUM_KEYS-1:0] levels, logic [7:0] margin,
                              logic [6:0] qualify);
    settle_block();
    for (int i = 0; i < akd_pkg::NUM_KEYS; i++)
      write_reg(CFG_KEY_LEVEL_0 + 3'(i), levels[8*i +: 8]);
    write_reg(akd_pkg::CFG_MATCH_MARGIN, margin);
    write_reg(akd_pkg::CFG_QUALIFY_COUNT, {1'b0, qualify});
  endtask

  function automatic key_item_t random_item();
    int         k;
    int         s;
    logic [5:0] sample;
    if ($urandom_range(0, 99) < 40) begin
      k = $urandom_range(0, akd_pkg::NUM_KEYS - 1);
      s = (int'(key_level[k]) * SAMPLE_SPAN) / LEVEL_SPAN + $urandom_range(0, 2) - 1;
      if (s < 0) s = 0;
      if (s > SAMPLE_SPAN) s = SAMPLE_SPAN;
      sample = 6'(s);
    end else begin
      sample = 6'($urandom_range(0, 63));
    end
    return make_item($urandom_range(0, 99) < 25, $urandom_range(0, 99) < 45,
                     $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 8, sample);
  endfunction

  task automatic test_default_registers();
    send_poll();
    send_irq(1'b0, 1'b0, 1'b0, 6'd63);
    send_irq(1'b1, 1'b0, 1'b0, 6'd0);
    send_irq(1'b0, 1'b1, 1'b0, 6'd0);
    send_irq(1'b1, 1'b1, 1'b0, KEY_SAMPLE[0]);
    send_poll();
    // The counter now rests at the qualify count, so flagless interrupts re-latch.
    for (int k = 1; k < akd_pkg::NUM_KEYS; k++) begin
      send_irq(1'b0, 1'b0, 1'b0, KEY_SAMPLE[k]);
      send_poll();
    end
    send_irq(1'b0, 1'b0, 1'b0, 6'd63);
    send_poll();
    send_irq(1'b0, 1'b0, 1'b1, 6'd20);
    send_irq(1'b1, 1'b0, 1'b0, 6'd1);
    send_irq(1'b0, 1'b1, 1'b0, 6'd2);
    // Press and release in one item: the release wins, the new level stays.
    send_irq(1'b1, 1'b1, 1'b1, 6'd50);
    send_poll();
    send_poll();
  endtask

  task automatic test_zero_qualify();
    apply_config({8'd50, 8'd100, 8'd1, 8'd200, 8'd255, 8'd0}, 8'd0, 7'd0);
    send_irq(1'b0, 1'b0, 1'b0, 6'd0);
    send_poll();
    send_irq(1'b1, 1'b0, 1'b0, 6'd5);
    send_poll();
    send_irq(1'b0, 1'b0, 1'b1, 6'd9);
    send_poll();
    send_irq(1'b0, 1'b0, 1'b0, 6'd63);
    send_poll();
    settle_block();
    write_reg(akd_pkg::CFG_MATCH_MARGIN, 8'd1);
    send_irq(1'b0, 1'b0, 1'b0, 6'd63);
    send_poll();
  endtask

  task automatic test_wide_window();
    apply_config({8'd128, 8'd64, 8'd200, 8'd255, 8'd0, 8'd255}, 8'd255, 7'd1);
    send_irq(1'b1, 1'b0, 1'b0, 6'd0);
    send_poll();
    send_irq(1'b0, 1'b0, 1'b1, 6'd0);
    send_irq(1'b0, 1'b1, 1'b0, 6'd63);
    send_poll();
    for (int n = 0; n < 20; n++) send_item(random_item());
  endtask

  task automatic test_counter_saturation();
    logic [1:0] f;
    apply_config({8'd123, 8'd114, 8'd101, 8'd85, 8'd57, 8'd12}, 8'd5, 7'd100);
    for (int pass = 0; pass < 2; pass++) begin
      for (int n = 0; n < 110; n++) begin
        f = 2'($urandom_range(1, 3));
        send_irq(f[0], f[1], 1'b0, 6'($urandom_range(0, 63)));
        if (n % 10 == 9) send_poll();
      end
      send_irq(1'b0, 1'b0, 1'b1, 6'd0);
      send_poll();
      // A qualify count above the saturation point can never be reached.
      if (pass == 0) begin
        settle_block();
        write_reg(akd_pkg::CFG_QUALIFY_COUNT, 8'd127);
      end
    end
  endtask

  task automatic test_receiver_stall();
    apply_config({8'd123, 8'd114, 8'd101, 8'd85, 8'd57, 8'd12}, 8'd5, 7'd2);
    steady    = 1'b1;
    hold_left = STALL_CYCLES;
    for (int n = 0; n < 60; n++) send_item(random_item());
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [8*akd_pkg::NUM_KEYS-1:0] levels;
    logic [7:0]                     margin;
    logic [6:0]                     qualify;
    int                             r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int i = 0; i < akd_pkg::NUM_KEYS; i++) begin
        if ($urandom_range(0, 99) < 15) levels[8*i +: 8] = 8'($urandom_range(0, 255));
        else levels[8*i +: 8] = 8'(($urandom_range(0, 63) * LEVEL_SPAN) / SAMPLE_SPAN);
      end
      r = $urandom_range(0, 99);
      margin = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(1, 12));
      r = $urandom_range(0, 99);
      qualify = (r < 10) ? 7'd0 : (r < 20) ? 7'($urandom_range(100, 127))
                                           : 7'($urandom_range(1, 6));
      apply_config(levels, margin, qualify);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 2) == 0);
        send_item(random_item());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_action       = ACT_INTERRUPT;
    in_sample_flag  = 1'b0;
    in_press_flag   = 1'b0;
    in_release_flag = 1'b0;
    in_adc_sample   = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_KEY_LEVEL_0;
    cfg_data        = '0;
    for (int i = 0; i < akd_pkg::NUM_KEYS; i++) key_level[i] = akd_pkg::LEVEL_RESET[i];
    window_margin = akd_pkg::MARGIN_RESET;
    qualify_at    = akd_pkg::QUALIFY_RESET;
    press_count   = '0;
    pending_event = akd_pkg::EV_NONE;
    held_level    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_registers();
    test_zero_qualify();
    test_wide_window();
    test_counter_saturation();
    test_receiver_stall();
    test_random_phases();
    settle_block();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/akd_pkg.sv
rtl/akd_front.sv
rtl/akd_cmd_fifo.sv
rtl/akd_back.sv
rtl/adc_ladder_key_decoder.sv
tb/sv/testbench.sv
